### hw/rtl/three_wire_serial_command_sender_macros.svh
// Assertion macros shared by the serial command sender RTL.
`ifndef THREE_WIRE_SERIAL_COMMAND_SENDER_MACROS_SVH
`define THREE_WIRE_SERIAL_COMMAND_SENDER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TWS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tws assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tws assertion failed");

`endif

### hw/rtl/tws_pkg.sv
// Package with constants and types of the three-wire serial command sender.
`default_nettype none

package tws_pkg;

    localparam int COMMAND_BITS_DEF = 7;
    localparam int PAYLOAD_BITS_DEF = 8;
    localparam int DELAY_W          = 8;

    // Request kinds carried in tuser.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Phases with fixed pin actions; bit phases follow from FIRST_BIT_PHASE.
    localparam int PH_IDLE         = 0;
    localparam int PH_CLK_HIGH     = 1;
    localparam int PH_SELECT_LOW   = 2;
    localparam int PH_START_BIT    = 3;
    localparam int PH_CLK_RISE     = 4;
    localparam int FIRST_BIT_PHASE = 5;

    localparam int RESULT_W     = 6;
    localparam int RESULT_PAD_W = 8;

    typedef struct packed {
        logic rejected;
        logic done_res;
        logic busy_res;
        logic data_line;
        logic select_line;
        logic clock_line;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/three_wire_serial_command_sender.sv
// Top level of the three-wire serial command sender.
//
//  channel   | ports                         | contents
//  ----------+-------------------------------+--------------------------------------
//  request   | s_tvalid/s_tready/s_tdata/tuser | start (code, payload) or time tick
//  result    | m_tvalid/m_tready/m_tdata     | pin levels and status after a request
//  config    | i_cfg_we/i_cfg_wdata          | ticks_per_delay
//
// Every request is decided combinationally: the state and result registers are
// updated at the edge where it is accepted, so one request per cycle unless stalled.
// A request is accepted while the result register is empty or being taken.
// Reset is synchronous and active low; it clears the state and the result valid.
// A stalled result holds its value; no request is taken until it drains.
`default_nettype none

`include "three_wire_serial_command_sender_macros.svh"

module three_wire_serial_command_sender #(
    parameter int COMMAND_BITS = tws_pkg::COMMAND_BITS_DEF,
    parameter int PAYLOAD_BITS = tws_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [tws_pkg::DELAY_W-1:0] i_cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // Fields from bit 0: command_code, payload_byte, zero fill.
    input  wire logic [((COMMAND_BITS+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,
    // Field: kind.
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // Fields from bit 0: clock_line, select_line, data_line, busy_res, done_res,
    // rejected, zero fill.
    output logic [tws_pkg::RESULT_PAD_W-1:0] m_tdata
);

    localparam int TOTAL_BITS = COMMAND_BITS + PAYLOAD_BITS;
    localparam int LAST_PHASE = 4 + 2 * TOTAL_BITS;
    localparam int PH_W       = $clog2(LAST_PHASE + 1);
    localparam int PN_W       = PH_W + 1;
    localparam int DW         = tws_pkg::DELAY_W;

    logic [DW-1:0]         r_ticks;
    logic [PH_W-1:0]       r_phase,   n_phase;
    logic [TOTAL_BITS-1:0] r_shift,   n_shift;
    logic [DW-1:0]         r_cnt,     n_cnt;
    logic                  r_clk_lvl, n_clk_lvl;
    logic                  r_sel_lvl, n_sel_lvl;
    logic                  r_dat_lvl, n_dat_lvl;
    logic                  r_active,  n_active;
    logic                  r_out_valid;
    tws_pkg::t_result      r_out,     n_out;

    logic                  accept;
    logic [DW-1:0]         limit;
    logic [DW-1:0]         cnt_inc;
    logic [PN_W-1:0]       next_ph;
    logic                  done;
    logic                  rej;

    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign limit    = (r_ticks == '0) ? DW'(1) : r_ticks;
    assign cnt_inc  = r_cnt + DW'(1);
    assign next_ph  = {1'b0, r_phase} + PN_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_shift   = r_shift;
        n_cnt     = r_cnt;
        n_clk_lvl = r_clk_lvl;
        n_sel_lvl = r_sel_lvl;
        n_dat_lvl = r_dat_lvl;
        n_active  = r_active;
        done      = 1'b0;
        rej       = 1'b0;
        if (s_tuser == tws_pkg::KIND_START) begin
            if (r_active) begin
                rej = 1'b1;
            end else begin
                n_shift   = {s_tdata[COMMAND_BITS-1:0],
                             s_tdata[TOTAL_BITS-1:COMMAND_BITS]};
                n_clk_lvl = 1'b1;
                n_phase   = PH_W'(tws_pkg::PH_CLK_HIGH);
                n_cnt     = '0;
                n_active  = 1'b1;
            end
        end else if (r_active) begin
            n_cnt = cnt_inc;
            if (cnt_inc >= limit) begin
                n_cnt = '0;
                if (next_ph > PN_W'(LAST_PHASE)) begin
                    n_sel_lvl = 1'b1;
                    n_active  = 1'b0;
                    n_phase   = PH_W'(tws_pkg::PH_IDLE);
                    done      = 1'b1;
                end else begin
                    n_phase = next_ph[PH_W-1:0];
                    if (next_ph == PN_W'(tws_pkg::PH_SELECT_LOW)) begin
                        n_sel_lvl = 1'b0;
                        n_clk_lvl = 1'b0;
                    end else if (next_ph == PN_W'(tws_pkg::PH_START_BIT)) begin
                        n_dat_lvl = 1'b0;
                    end else if (next_ph == PN_W'(tws_pkg::PH_CLK_RISE)) begin
                        n_clk_lvl = 1'b1;
                    end else if (next_ph >= PN_W'(tws_pkg::FIRST_BIT_PHASE)) begin
                        // Bit phases alternate: odd numbers put a bit out with the clock
                        // low, even numbers raise the clock.
                        if (next_ph[0]) begin
                            n_clk_lvl = 1'b0;
                            n_dat_lvl = r_shift[TOTAL_BITS-1];
                            n_shift   = r_shift << 1;
                        end else begin
                            n_clk_lvl = 1'b1;
                        end
                    end
                end
            end
        end
        n_out.clock_line  = n_clk_lvl;
        n_out.select_line = n_sel_lvl;
        n_out.data_line   = n_dat_lvl;
        n_out.busy_res    = n_active;
        n_out.done_res    = done;
        n_out.rejected    = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= DW'(1);
            r_phase     <= PH_W'(tws_pkg::PH_IDLE);
            r_shift     <= '0;
            r_cnt       <= '0;
            r_clk_lvl   <= 1'b1;
            r_sel_lvl   <= 1'b1;
            r_dat_lvl   <= 1'b1;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ticks <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_shift     <= n_shift;
                r_cnt       <= n_cnt;
                r_clk_lvl   <= n_clk_lvl;
                r_sel_lvl   <= n_sel_lvl;
                r_dat_lvl   <= n_dat_lvl;
                r_active    <= n_active;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(tws_pkg::RESULT_PAD_W - tws_pkg::RESULT_W){1'b0}}, r_out};

    `TWS_ASSERT_SAME(a_done_ends_transfer, i_clk, i_rst_n,
        r_out_valid && r_out.done_res, r_out.select_line && !r_out.busy_res)
    `TWS_ASSERT_SAME(a_idle_phase_zero, i_clk, i_rst_n,
        !r_active, r_phase == PH_W'(tws_pkg::PH_IDLE))
    `TWS_ASSERT_NEXT(a_reject_keeps_state, i_clk, i_rst_n,
        accept && s_tuser == tws_pkg::KIND_START && r_active,
        r_phase == $past(r_phase) && r_shift == $past(r_shift) && r_out.rejected)

endmodule

`default_nettype wire
